/* rtl/core/ihd_pkg.sv */
// package for the halfband decimator cascade: constants, types, shift helpers
// no dependencies
package ihd_pkg;

	localparam int DataW = 32;
	localparam int DelayDepth = 21;
	localparam int DelayAw = 5;
	localparam int PendDepth = 4;

	localparam logic [31:0] CoefA2 = 32'h0D9C6C2D;
	localparam logic [31:0] CoefA1 = 32'h77233802;
	localparam logic [31:0] CoefB1 = 32'h385BACD3;

	localparam logic [2:0] RatioNone = 3'd0;
	localparam logic [2:0] RatioBy2  = 3'd1;
	localparam logic [2:0] RatioBy4  = 3'd2;
	localparam logic [2:0] RatioBy8  = 3'd3;
	localparam logic [2:0] RatioBy16 = 3'd4;

	typedef enum logic [1:0] {
		SEC_SHIFT1,
		SEC_SHIFT2,
		SEC_MULT
	} sec_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_MUL,
		ST_OUT
	} ctl_state_t;

	// one section step handed from the sequencer to the datapath
	typedef struct packed {
		sec_kind_t        kind;
		logic [31:0]      early;
		logic [31:0]      late;
	} sec_cmd_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] coef1(input logic [31:0] x);
		return asr(x, 2) + asr(x, 4) + asr(x, 5);
	endfunction

	function automatic logic [2:0] chain_len(input logic [2:0] r);
		case (r)
			RatioBy2:  return 3'd1;
			RatioBy4:  return 3'd2;
			RatioBy8:  return 3'd3;
			RatioBy16: return 3'd4;
			default:   return 3'd0;
		endcase
	endfunction

	function automatic logic [DelayAw-1:0] delay_base(input logic [2:0] r);
		case (r)
			RatioBy4:  return 5'd3;
			RatioBy8:  return 5'd8;
			RatioBy16: return 5'd14;
			default:   return 5'd0;
		endcase
	endfunction

	function automatic sec_kind_t chain_kind(input logic [2:0] r, input logic [1:0] s);
		logic [2:0] pos;
		pos = chain_len(r) - 3'(s);
		case (pos)
			3'd1:    return SEC_MULT;
			3'd2:    return SEC_SHIFT2;
			default: return SEC_SHIFT1;
		endcase
	endfunction

	function automatic logic [31:0] pre_shift(input logic [2:0] r, input logic [31:0] x);
		case (r)
			RatioBy2:  return asr(x, 2);
			RatioBy4:  return asr(x, 3);
			RatioBy8:  return asr(x, 4);
			default:   return asr(x, 5);
		endcase
	endfunction

endpackage

/* rtl/core/ihd_delay_mem.sv */
// delay store: 21 x 3 words, one row per section, synchronous registered read
// depends on ihd_pkg
module ihd_delay_mem
	import ihd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [DelayAw-1:0] rd_addr,
	output logic [95:0]        rd_data,
	input  logic               wr_en,
	input  logic [DelayAw-1:0] wr_addr,
	input  logic [95:0]        wr_data
);
	// one row per section base address, holds up to three delay words
	logic [95:0]          mem [DelayDepth];
	logic [DelayDepth-1:0] valid_q;
	logic [95:0]          rd_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;
endmodule

/* rtl/core/ihd_section.sv */
// one allpass section step: for a mult section products are registered, then summed; shift sections are combinational
// depends on ihd_pkg
module ihd_section
	import ihd_pkg::*;
(
	input  logic        clk,
	input  logic        start,
	input  logic        finish,
	input  sec_cmd_t    cmd,
	input  logic [95:0] dly,
	output logic [31:0] result,
	output logic [95:0] dly_new
);
	logic [31:0] d0, d1, d2;
	logic [31:0] m1_s1, m2_s1, qb1_s1;
	logic [31:0] z0, b0, pa, pb, a0, sb0;

	assign d0 = dly[31:0];
	assign d1 = dly[63:32];
	assign d2 = dly[95:64];

	function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] c);
		logic signed [63:0] p;
		p = $signed(a) * $signed(c);
		return {p[62:32], 1'b0};
	endfunction

	// first step: products that only need stored delays
	always_ff @(posedge clk) begin
		if (start) begin
			m1_s1 <= qmul(d0, CoefA1);
			m2_s1 <= qmul(d1, CoefA2);
			qb1_s1 <= qmul(d2, CoefB1);
		end
	end

	logic [31:0] z0_q, b0_q;
	always_ff @(posedge clk) begin
		if (finish) begin
			z0_q <= cmd.late - m1_s1 - m2_s1;
			b0_q <= cmd.early - qb1_s1;
		end
	end

	logic [31:0] pz_q, pb_q;
	always_ff @(posedge clk) begin
		pz_q <= qmul(z0_q, CoefA2);
		pb_q <= qmul(b0_q, CoefB1);
	end

	assign z0 = z0_q;
	assign b0 = b0_q;

	always_comb begin
		result = '0;
		dly_new = dly;
		a0 = '0; sb0 = '0; pa = '0; pb = '0;
		case (cmd.kind)
			SEC_SHIFT1: begin
				a0 = cmd.late - coef1(d0);
				result = d0 + coef1(a0) + cmd.early;
				dly_new = {d2, d1, a0};
			end
			SEC_SHIFT2: begin
				a0 = cmd.late - asr(d0, 3);
				pa = d0 + asr(a0, 3);
				sb0 = cmd.early - asr(d1, 1) - asr(d1, 4);
				pb = d1 + asr(sb0, 1) + asr(sb0, 4);
				result = pa + pb;
				dly_new = {d2, sb0, a0};
			end
			SEC_MULT: begin
				pa = m1_s1 + pz_q + d1;
				pb = pb_q + d2;
				result = pa + pb;
				dly_new = {b0, d0, z0};
			end
			default: ;
		endcase
	end
endmodule

/* rtl/core/iir_halfband_decimator_cascade_core.sv */
// top level of the halfband decimator cascade: sequencer, pending regs, output reg
// depends on ihd_pkg, ihd_delay_mem, ihd_section
//
//  channel   | signals                         | accepted when
//  input     | in_valid, in_stall, sample_in   | in_valid && !in_stall
//  output    | out_valid, out_stall, sample_out| out_valid && !out_stall
//  config    | cfg_we, cfg_data                | cfg_we
//
// a sample runs its sections one at a time: a shift section takes read, product and
// write-back steps, a mult section adds multiply steps, and the section where the
// sample is the first of its pair takes a single read step; an item holds the input
// from its accept until its last step is done.
// reset clears phase, ratio and valid bits; delays read zero until written.
// a result waiting on a stalled output holds the next result at its write-back only;
// the input stalls while an item is in flight.
module iir_halfband_decimator_cascade_core
	import ihd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sample_out
);
	ctl_state_t state_q, state_d;
	logic [2:0]  ratio_q;
	logic [3:0]  phase_q;
	logic [1:0]  sec_q;
	logic [2:0]  cnt_q;
	logic [31:0] v_q;
	logic [DelayAw-1:0] off_q;
	logic [31:0] pend_q [PendDepth];
	logic [31:0] out_q;
	logic        out_v_q;

	logic        accept, active;
	logic [2:0]  n;
	logic [3:0]  phase_mask;
	sec_kind_t   kind;
	sec_cmd_t    cmd;
	logic [95:0] rd_data, dly_new;
	logic [31:0] sec_res;
	logic        rd_en, wr_en, sec_start, sec_finish;
	logic [2:0]  last_cnt;
	logic        last_sec, out_hold;

	assign active = (ratio_q >= RatioBy2) && (ratio_q <= RatioBy16);
	assign n = chain_len(ratio_q);
	assign phase_mask = 4'((5'd1 << n) - 5'd1);
	assign kind = chain_kind(ratio_q, sec_q);
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign cmd = '{kind: kind, early: pend_q[sec_q], late: v_q};
	assign last_cnt = (kind == SEC_MULT) ? 3'd3 : 3'd0;
	assign last_sec = (3'(sec_q) + 3'd1 == n);
	// previous result still waiting, hold the write-back of the new one
	assign out_hold = last_sec && out_v_q && out_stall;

	ihd_delay_mem u_mem (
		.clk(clk), .arst_n(arst_n),
		.rd_en(rd_en), .rd_addr(off_q), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(off_q), .wr_data(dly_new)
	);

	ihd_section u_sec (
		.clk(clk), .start(sec_start), .finish(sec_finish), .cmd(cmd),
		.dly(rd_data), .result(sec_res), .dly_new(dly_new)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && active) state_d = ST_READ;
			ST_READ: begin
				if (!phase_q[sec_q]) state_d = ST_IDLE;
				else state_d = ST_CALC;
			end
			ST_CALC: state_d = (kind == SEC_MULT) ? ST_MUL : ST_OUT;
			ST_MUL:  if (cnt_q == last_cnt) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_hold) state_d = last_sec ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd_en = 1'b0;
		sec_start = 1'b0;
		sec_finish = 1'b0;
		wr_en = 1'b0;
		case (state_q)
			ST_READ: rd_en = phase_q[sec_q];
			ST_CALC: begin
				sec_start = 1'b1;
			end
			ST_MUL:  sec_finish = (cnt_q == 3'd0);
			ST_OUT:  wr_en = !out_hold;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ratio_q <= RatioNone;
			phase_q <= '0;
			sec_q <= '0;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && last_sec && !out_hold) out_v_q <= 1'b1;
			else if (!out_stall) out_v_q <= 1'b0;
			if (cfg_we) begin
				ratio_q <= cfg_data;
				phase_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					sec_q <= '0;
					cnt_q <= '0;
				end
				ST_READ: begin
					cnt_q <= '0;
					if (!phase_q[sec_q]) phase_q <= (phase_q + 4'd1) & phase_mask;
				end
				ST_MUL: cnt_q <= cnt_q + 3'd1;
				ST_OUT: begin
					if (!out_hold) begin
						if (last_sec) phase_q <= (phase_q + 4'd1) & phase_mask;
						sec_q <= sec_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// for shift sections the result is combinational off the read row
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= pre_shift(ratio_q, sample_in);
			off_q <= delay_base(ratio_q);
		end
		if (state_q == ST_READ && !phase_q[sec_q]) pend_q[sec_q] <= v_q;
		if (state_q == ST_OUT && !out_hold) begin
			v_q <= sec_res;
			off_q <= off_q + ((kind == SEC_SHIFT1) ? 5'd1 : (kind == SEC_SHIFT2) ? 5'd2 : 5'd3);
			if (last_sec) out_q <= sec_res + asr(sec_res, 1);
		end
	end

	assign out_valid = out_v_q;
	assign sample_out = out_q;
endmodule

/* tb/testbench.sv */
// testbench for the halfband decimator cascade: directed table, then random samples,
// checked against an in-bench model of the allpass sections; depends on ihd_pkg and the core
module testbench
	import ihd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_data = RatioNone;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] sample_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] sample_out;

	iir_halfband_decimator_cascade_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state
	logic [31:0] dly [DelayDepth];
	logic [31:0] pend [PendDepth];
	logic [3:0]  phase;
	logic [2:0]  ratio;

	logic [31:0] want_q [$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit sending_done = 1'b0;

	function automatic logic [31:0] sar(logic [31:0] x, int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] q31_mul(logic [31:0] a, logic [31:0] c);
		logic signed [63:0] p;
		p = $signed(a) * $signed(c);
		return {p[62:32], 1'b0};
	endfunction

	function automatic logic [31:0] mul_coef(logic [31:0] x);
		return sar(x, 2) + sar(x, 4) + sar(x, 5);
	endfunction

	// advance the model by one sample; returns 1 with the decimated value
	function automatic bit decimate(input logic [31:0] x, output logic [31:0] y);
		logic [31:0] v, e, z0, z1, z2, a0, b0, pa, pb, m1, m2;
		int n, off;
		sec_kind_t k;
		y = '0;
		if (ratio < RatioBy2 || ratio > RatioBy16) return 0;
		n = ratio;
		v = sar(x, ratio + 1);
		off = (ratio == RatioBy4) ? 3 : (ratio == RatioBy8) ? 8 : (ratio == RatioBy16) ? 14 : 0;
		for (int s = 0; s < n; s++) begin
			if (!phase[s]) begin
				pend[s] = v;
				phase = 4'((phase + 1) & ((1 << n) - 1));
				return 0;
			end
			e = pend[s];
			k = (n - s == 1) ? SEC_MULT : (n - s == 2) ? SEC_SHIFT2 : SEC_SHIFT1;
			case (k)
				SEC_SHIFT1: begin
					z1 = dly[off];
					z0 = v - mul_coef(z1);
					dly[off] = z0;
					v = z1 + mul_coef(z0) + e;
					off += 1;
				end
				SEC_SHIFT2: begin
					a0 = v - sar(dly[off], 3);
					pa = dly[off] + sar(a0, 3);
					b0 = e - sar(dly[off+1], 1) - sar(dly[off+1], 4);
					pb = dly[off+1] + sar(b0, 1) + sar(b0, 4);
					dly[off] = a0;
					dly[off+1] = b0;
					v = pa + pb;
					off += 2;
				end
				default: begin
					z1 = dly[off];
					z2 = dly[off+1];
					m1 = q31_mul(z1, CoefA1);
					m2 = q31_mul(z2, CoefA2);
					z0 = v - m1 - m2;
					pa = m1 + q31_mul(z0, CoefA2) + z2;
					b0 = e - q31_mul(dly[off+2], CoefB1);
					pb = q31_mul(b0, CoefB1) + dly[off+2];
					dly[off+1] = z1;
					dly[off] = z0;
					dly[off+2] = b0;
					v = pa + pb;
					off += 3;
				end
			endcase
		end
		phase = 4'((phase + 1) & ((1 << n) - 1));
		y = sar(v, 1) + v;
		return 1;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	// valid stays up after the accepting edge; set_ratio, or the next call when it waits a gap, drops it
	task automatic send_sample(input logic [31:0] x);
		logic [31:0] y;
		int g;
		g = gap_len();
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		do @(posedge clk); while (in_stall);
		if (decimate(x, y)) want_q.push_back(y);
	endtask

	task automatic set_ratio(input logic [2:0] r);
		in_valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		ratio = r;
		phase = '0;
	endtask

	task automatic rand_block(input int cnt);
		logic [31:0] x;
		for (int i = 0; i < cnt; i++) begin
			case ($urandom_range(0, 5))
				0: x = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
				1: x = 32'($signed($urandom_range(0, 2000)) - 1000);
				default: x = $urandom;
			endcase
			send_sample(x);
		end
	endtask

	// directed rows: ratio, sample, whether the expected value is typed in, that value
	typedef struct {
		logic [2:0]  r;
		logic [31:0] x;
		bit          fixed;
		logic [31:0] y;
	} row_t;

	row_t rows [] = '{
		'{RatioBy2, 32'h0, 1'b0, 32'h0},
		'{RatioBy2, 32'h0, 1'b1, 32'h0},
		'{RatioBy2, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{RatioBy2, 32'h80000000, 1'b0, 32'h0},
		'{RatioBy2, 32'hFFFFFFFF, 1'b0, 32'h0},
		'{RatioBy2, 32'h00000001, 1'b0, 32'h0},
		'{RatioBy4, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{RatioBy4, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{RatioBy4, 32'h80000000, 1'b0, 32'h0},
		'{RatioBy4, 32'h80000000, 1'b0, 32'h0},
		'{RatioBy8, 32'h12345678, 1'b0, 32'h0},
		'{RatioBy8, 32'hEDCBA987, 1'b0, 32'h0},
		'{RatioBy8, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{RatioBy8, 32'h80000000, 1'b0, 32'h0},
		'{RatioBy16, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{RatioBy16, 32'h80000000, 1'b0, 32'h0},
		'{RatioBy16, 32'h55555555, 1'b0, 32'h0},
		'{RatioBy16, 32'hAAAAAAAA, 1'b0, 32'h0},
		'{RatioNone, 32'h7FFFFFFF, 1'b0, 32'h0},
		'{3'd7, 32'h80000000, 1'b0, 32'h0}
	};

	initial begin
		logic [2:0] cur;
		foreach (dly[i]) dly[i] = '0;
		foreach (pend[i]) pend[i] = '0;
		phase = '0;
		ratio = RatioNone;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur = 3'd0;
		foreach (rows[i]) begin
			if (rows[i].r != cur || i == 0) begin
				set_ratio(rows[i].r);
				cur = rows[i].r;
			end
			send_sample(rows[i].x);
			if (rows[i].fixed && want_q.size() != 0 && want_q[$] != rows[i].y) begin
				errors++;
				if (errors <= 10)
					$display("table row %0d: model gives %h, table %h", i, want_q[$], rows[i].y);
			end
		end
		// random phases, extremes of ratio included
		set_ratio(RatioBy16);
		hold_off = 1'b1;
		rand_block(150);
		hold_off = 1'b0;
		set_ratio(RatioBy2);
		rand_block(120);
		set_ratio(RatioNone);
		rand_block(20);
		set_ratio(RatioBy4);
		rand_block(120);
		set_ratio(RatioBy8);
		rand_block(150);
		set_ratio(RatioBy16);
		rand_block(170);
		set_ratio(3'($urandom_range(1, 4)));
		rand_block(40);
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// output side: random stall, one long hold-off while the input keeps coming
	initial begin
		int g;
		wait (arst_n && hold_off);
		out_stall <= 1'b1;
		repeat (300) @(posedge clk);
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 3) == 0) begin
				g = gap_len();
				if (g > 0) begin
					out_stall <= 1'b1;
					repeat (g) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// compare each accepted beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (want_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output beat %h", sample_out);
			end else begin
				if (sample_out !== want_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("sample_out mismatch: expected %h, got %h", want_q[0], sample_out);
				end
				void'(want_q.pop_front());
			end
		end
	end

	initial begin
		wait (sending_done);
		while (want_q.size() != 0 && cycles < 400000) @(posedge clk);
		repeat (60) @(posedge clk);
		if (want_q.size() != 0) errors++;
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 500000) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

/* filelist.f */
rtl/core/ihd_pkg.sv
rtl/core/ihd_delay_mem.sv
rtl/core/ihd_section.sv
rtl/core/iir_halfband_decimator_cascade_core.sv
tb/testbench.sv
